### sv/vrba_pkg.sv
// ----------------------------------------------------------------------------
// vrba_pkg
// Shared types and constants of the variable-size ring buffer allocator.
// ----------------------------------------------------------------------------
package vrba_pkg;

  localparam int HDR_BYTES   = 8;   // header size, also the slot size
  localparam int ALIGN_W     = 3;   // log2 of the slot size
  localparam int ST_W        = 2;   // header state bits
  localparam int REQ_BYTES_W = 13;
  localparam int OFF_W       = 12;
  localparam int SZ_W        = 14;  // rounded request size, up to 8192 + header

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_COMMIT = 2'd1,
    REQ_FRONT  = 2'd2,
    REQ_POP    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    HS_EMPTY  = 2'd0,
    HS_ALLOC  = 2'd1,
    HS_COMMIT = 2'd2,
    HS_PAD    = 2'd3
  } hdr_st_e;

  typedef struct packed {
    req_type_e              req_type;
    logic [REQ_BYTES_W-1:0] req_bytes;
    logic [OFF_W-1:0]       data_offset;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] result_offset;
    logic [OFF_W-1:0] result_bytes;
  } res_t;

endpackage

### sv/variable_ring_buffer_allocator_top.sv
// ----------------------------------------------------------------------------
// variable_ring_buffer_allocator_top
// Bookkeeping for a circular buffer of variable-size FIFO entries.
// ----------------------------------------------------------------------------
//  channel  dir  tdata [lsb..]                        tuser
//  s_axis   in   req_bytes[12:0], data_offset[24:13]  req_type[1:0]
//  m_axis   out  result_offset[11:0], result_bytes    status[0]
//
//  Each item passes through the idle and execute states, and no new item is
//  taken until it is done; allocate executes again when it pads to the buffer
//  end, and front reads the new head header for each padding entry it frees.
//  After reset a clearing pass writes every header slot, CAPACITY_BYTES / 8
//  of them (512 by default), with s_axis_tready low.
//  Results go through an output register; one that stays full holds the item
//  in the engine, and no new item is taken until it has moved on.
// ----------------------------------------------------------------------------
module variable_ring_buffer_allocator_top #(
  parameter int CAPACITY_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // req_bytes[12:0], data_offset[24:13]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // result_offset[11:0], result_bytes[23:12]
  output logic [0:0]  m_axis_tuser   // status[0]
);

  import vrba_pkg::*;

  localparam int NUM_SLOTS = CAPACITY_BYTES / HDR_BYTES;
  localparam int AW        = $clog2(NUM_SLOTS);
  localparam int HW        = ST_W + $clog2(CAPACITY_BYTES);

  req_t          req;
  res_t          res;
  logic          res_valid, res_ready;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [HW-1:0] mem_wdata, mem_rdata;
  logic          out_valid_q;
  res_t          out_q;

  assign req.req_type    = req_type_e'(s_axis_tuser);
  assign req.req_bytes   = s_axis_tdata[REQ_BYTES_W-1:0];
  assign req.data_offset = s_axis_tdata[REQ_BYTES_W +: OFF_W];

  vrba_engine #(
    .CAPACITY_BYTES (CAPACITY_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  vrba_hdr_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (HW)
  ) u_hdr_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.result_bytes, out_q.result_offset};
  assign m_axis_tuser  = out_q.status;

endmodule

### sv/vrba_hdr_mem.sv
// ----------------------------------------------------------------------------
// vrba_hdr_mem
// Header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vrba_hdr_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 14
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vrba_engine.sv
// ----------------------------------------------------------------------------
// vrba_engine
// Request sequencer: cursors, used count, header read-modify-write, clear pass.
// ----------------------------------------------------------------------------
module vrba_engine #(
  parameter int CAPACITY_BYTES = 4096,
  localparam int NUM_SLOTS = CAPACITY_BYTES / vrba_pkg::HDR_BYTES,
  localparam int AW        = $clog2(NUM_SLOTS),
  localparam int POS_W     = $clog2(CAPACITY_BYTES),
  localparam int HW        = vrba_pkg::ST_W + POS_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  vrba_pkg::req_t  req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output vrba_pkg::res_t  res_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [HW-1:0]   mem_wdata_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [HW-1:0]   mem_rdata_i
);

  import vrba_pkg::*;

  localparam int CW = ((POS_W + 1 > SZ_W) ? POS_W + 1 : SZ_W) + 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 2);
  localparam int MOD_STEPS = (CAPACITY_BYTES >= (1 << OFF_W)) ? 1 :
                             $clog2((1 << OFF_W) / CAPACITY_BYTES) + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  state_e            state_q, state_d;
  req_type_e         type_q, type_d;
  logic [SZ_W-1:0]   size_q, size_d;
  logic [SZ_W-1:0]   esize_q, esize_d;
  logic [AW-1:0]     cslot_q, cslot_d;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic [POS_W-1:0]  rpos_q, rpos_d;
  logic [POS_W:0]    used_q, used_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     clr_q, clr_d;

  // offset reduced modulo the capacity, one conditional subtract per step
  function automatic logic [OFF_W-1:0] mod_cap(input logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] r;
    r = v;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(r) >= (32'(CAPACITY_BYTES) << k)) begin
        r = r - OFF_W'(32'(CAPACITY_BYTES) << k);
      end
    end
    return r;
  endfunction

  // request decode
  logic [SZ_W-1:0]  sz_raw, sz_in, esz_in;
  logic [OFF_W-1:0] dmod;
  logic [POS_W-1:0] dm_p, hpos;
  logic [AW-1:0]    cslot_in;

  always_comb begin
    sz_raw   = SZ_W'(req_i.req_bytes) + SZ_W'(HDR_BYTES - 1);
    sz_in    = {sz_raw[SZ_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    esz_in   = sz_in + SZ_W'(HDR_BYTES);
    dmod     = mod_cap(req_i.data_offset);
    dm_p     = POS_W'(dmod);
    hpos     = (dm_p >= POS_W'(HDR_BYTES)) ? dm_p - POS_W'(HDR_BYTES)
                                           : dm_p + POS_W'(CAPACITY_BYTES - HDR_BYTES);
    cslot_in = AW'(hpos >> ALIGN_W);
  end

  // header word fields
  hdr_st_e          hdr_st;
  logic [POS_W-1:0] hdr_sz;
  assign hdr_st = hdr_st_e'(mem_rdata_i[HW-1 -: ST_W]);
  assign hdr_sz = mem_rdata_i[POS_W-1:0];

  // allocate arithmetic
  logic [CW-1:0] used_w, esize_w, size_w, left_w, wsum_w, wnxt_w;
  logic          fit, need_pad, pad_ok;

  always_comb begin
    used_w   = CW'(used_q);
    esize_w  = CW'(esize_q);
    size_w   = CW'(size_q);
    left_w   = CW'(CAPACITY_BYTES) - CW'(wpos_q);
    fit      = (esize_w + used_w) <= CW'(CAPACITY_BYTES);
    need_pad = !((left_w >= size_w + CW'(2 * HDR_BYTES)) || (left_w == esize_w));
    pad_ok   = (used_w + left_w) <= CW'(CAPACITY_BYTES);
    wsum_w   = CW'(wpos_q) + esize_w;
    wnxt_w   = (wsum_w >= CW'(CAPACITY_BYTES)) ? wsum_w - CW'(CAPACITY_BYTES) : wsum_w;
  end

  // head release arithmetic
  logic [POS_W:0]   esz_h;
  logic [POS_W+1:0] rsum;
  logic [POS_W-1:0] rpos_nxt;
  logic [POS_W:0]   used_rel;
  logic [OFF_W-1:0] head_off;
  logic [AW+3:0]    coff;

  always_comb begin
    esz_h    = (POS_W + 1)'(hdr_sz) + (POS_W + 1)'(HDR_BYTES);
    rsum     = (POS_W + 2)'(rpos_q) + (POS_W + 2)'(esz_h);
    rpos_nxt = (rsum >= (POS_W + 2)'(CAPACITY_BYTES))
               ? POS_W'(rsum - (POS_W + 2)'(CAPACITY_BYTES)) : POS_W'(rsum);
    used_rel = (used_q >= esz_h) ? used_q - esz_h : '0;
    head_off = OFF_W'((POS_W + 1)'(rpos_q) + (POS_W + 1)'(HDR_BYTES));
    coff     = {1'b0, cslot_q, {ALIGN_W{1'b0}}} + (AW + 4)'(HDR_BYTES);
  end

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    size_d      = size_q;
    esize_d     = esize_q;
    cslot_d     = cslot_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(rpos_q >> ALIGN_W);
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(rpos_q >> ALIGN_W);

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(NUM_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          type_d   = req_i.req_type;
          size_d   = sz_in;
          esize_d  = esz_in;
          cslot_d  = cslot_in;
          cnt_d    = '0;
          mem_re_o = 1'b1;
          if (req_i.req_type == REQ_COMMIT) begin
            mem_raddr_o = cslot_in;
          end
          state_d = S_EXEC;
        end
      end

      S_READ: begin
        mem_re_o = 1'b1;
        state_d  = S_EXEC;
      end

      S_EXEC: begin
        case (type_q)
          REQ_ALLOC: begin
            mem_waddr_o = AW'(wpos_q >> ALIGN_W);
            if (!fit || (need_pad && !pad_ok)) begin
              res_valid_o  = 1'b1;
              res_o.status = 1'b1;
              if (res_ready_i) state_d = S_IDLE;
            end else if (need_pad) begin
              // fill to the buffer end, then retry from offset zero
              mem_we_o    = 1'b1;
              mem_wdata_o = {HS_PAD, POS_W'(left_w - CW'(HDR_BYTES))};
              used_d      = (POS_W + 1)'(used_w + left_w);
              wpos_d      = '0;
            end else begin
              res_valid_o         = 1'b1;
              res_o.result_offset = OFF_W'((POS_W + 1)'(wpos_q) + (POS_W + 1)'(HDR_BYTES));
              res_o.result_bytes  = OFF_W'(size_q);
              if (res_ready_i) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = {HS_ALLOC, POS_W'(size_q)};
                wpos_d      = POS_W'(wnxt_w);
                used_d      = (POS_W + 1)'(used_w + esize_w);
                state_d     = S_IDLE;
              end
            end
          end

          REQ_COMMIT: begin
            res_valid_o = 1'b1;
            mem_waddr_o = cslot_q;
            if (hdr_st == HS_ALLOC) begin
              res_o.result_offset = OFF_W'(coff);
              res_o.result_bytes  = OFF_W'(hdr_sz);
              mem_we_o            = res_ready_i;
              mem_wdata_o         = {HS_COMMIT, hdr_sz};
            end else begin
              res_o.status = 1'b1;
            end
            if (res_ready_i) state_d = S_IDLE;
          end

          REQ_FRONT: begin
            if (cnt_q != CNT_W'(NUM_SLOTS + 1) && hdr_st == HS_PAD) begin
              // drop the padding at the head and look at the next header
              mem_we_o = 1'b1;
              rpos_d   = rpos_nxt;
              used_d   = used_rel;
              cnt_d    = cnt_q + CNT_W'(1);
              state_d  = S_READ;
            end else begin
              res_valid_o = 1'b1;
              if (cnt_q != CNT_W'(NUM_SLOTS + 1) && hdr_st == HS_COMMIT) begin
                res_o.result_offset = head_off;
                res_o.result_bytes  = OFF_W'(hdr_sz);
              end else begin
                res_o.status = 1'b1;
              end
              if (res_ready_i) state_d = S_IDLE;
            end
          end

          REQ_POP: begin
            res_valid_o = 1'b1;
            if (hdr_st == HS_EMPTY || hdr_st == HS_ALLOC) begin
              res_o.status = 1'b1;
            end else begin
              res_o.result_offset = head_off;
              res_o.result_bytes  = OFF_W'(hdr_sz);
              if (res_ready_i) begin
                mem_we_o = 1'b1;
                rpos_d   = rpos_nxt;
                used_d   = used_rel;
              end
            end
            if (res_ready_i) state_d = S_IDLE;
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      wpos_q  <= '0;
      rpos_q  <= '0;
      used_q  <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
      used_q  <= used_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    size_q  <= size_d;
    esize_q <= esize_d;
    cslot_q <= cslot_d;
  end

  a_cursor_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wpos_q[ALIGN_W-1:0] == '0) && (rpos_q[ALIGN_W-1:0] == '0))
    else $error("cursor off slot boundary");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (POS_W + 1)'(CAPACITY_BYTES))
    else $error("used count above capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item not executed next cycle");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o)))
    else $error("header read and write collide");

endmodule
